// ===== src/assert_macros.svh =====
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== src/sol_pkg.sv =====
package sol_pkg;

    localparam int CMD_W      = 2;
    localparam int POS_W      = 6;
    localparam int CARD_W     = 6;
    localparam int LET_W      = 5;
    localparam int ALPHA      = 26;
    localparam int MAX_ROUNDS = 256;
    localparam int RND_W      = $clog2(MAX_ROUNDS);

    localparam logic [CMD_W-1:0] OP_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] OP_ENC  = 2'd1;
    localparam logic [CMD_W-1:0] OP_DEC  = 2'd2;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_SCAN_A = 4'd1;
    localparam logic [3:0] PH_COPY_A = 4'd2;
    localparam logic [3:0] PH_SCAN_B = 4'd3;
    localparam logic [3:0] PH_COPY_B = 4'd4;
    localparam logic [3:0] PH_SCAN_T = 4'd5;
    localparam logic [3:0] PH_COPY_T = 4'd6;
    localparam logic [3:0] PH_RD_BOT = 4'd7;
    localparam logic [3:0] PH_COPY_C = 4'd8;
    localparam logic [3:0] PH_RD_TOP = 4'd9;
    localparam logic [3:0] PH_RD_OUT = 4'd10;
    localparam logic [3:0] PH_EMIT   = 4'd11;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  position;
        logic [CARD_W-1:0] card;
        logic [LET_W-1:0]  letter;
    } item_t;

    typedef struct packed {
        logic [LET_W-1:0] out_letter;
        logic [LET_W-1:0] key_value;
    } result_t;

    typedef struct packed {
        logic [3:0] phase;
        logic       clr;
        logic       clr_scan;
        logic       flip;
        logic       start;
        logic       load;
        logic       emit;
        logic       zero;
        logic       key_zero;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic c_joker;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== src/sol_ram.sv =====
module sol_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 54
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/sol_dp.sv =====
module sol_dp #(
    parameter int DECK_SIZE = 54
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sol_pkg::dp_cmd_t dcmd,
    output sol_pkg::dp_sts_t dsts,
    input  sol_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output sol_pkg::result_t result
);

    localparam int AW = $clog2(DECK_SIZE);
    localparam int CW = $clog2(DECK_SIZE + 1);
    localparam int IW = CW + 1;
    localparam logic [IW-1:0] N_I    = IW'(DECK_SIZE);
    localparam logic [IW-1:0] LAST_I = IW'(DECK_SIZE - 1);
    localparam logic [IW-1:0] ONE_I  = IW'(1);
    localparam logic [IW-1:0] TWO_I  = IW'(2);

    logic [CW-1:0]               cnt_reg;
    logic                        pv_reg;
    logic [AW-1:0]               pidx_reg;
    logic                        bank_reg;
    logic [AW-1:0]               pa_reg, pb_reg, lo_reg, hi_reg;
    logic                        fa_reg, fb_reg, fj_reg;
    logic [sol_pkg::CARD_W-1:0]  v_reg, t_reg, c_reg;
    logic [sol_pkg::CMD_W-1:0]   op_reg;
    logic [sol_pkg::LET_W-1:0]   let_reg;
    logic                        out_vld_reg;
    sol_pkg::result_t            out_reg;

    function automatic logic is_jk(input logic [sol_pkg::CARD_W-1:0] d);
        is_jk = (IW'(d) == LAST_I) || (IW'(d) == N_I);
    endfunction

    logic                       is_scan, is_copy, is_rd, issue;
    logic [CW-1:0]              len;
    logic [sol_pkg::CARD_W-1:0] rdata, rd0, rd1;
    logic [IW-1:0]              j, rf, rt, src, n1, mid, ncut, vi;
    logic                       rel_id, cut_skip;
    logic [IW-1:0]              ts;
    logic [AW-1:0]              raddr;

    assign is_scan = (dcmd.phase == sol_pkg::PH_SCAN_A) || (dcmd.phase == sol_pkg::PH_SCAN_B)
                  || (dcmd.phase == sol_pkg::PH_SCAN_T);
    assign is_copy = (dcmd.phase == sol_pkg::PH_COPY_A) || (dcmd.phase == sol_pkg::PH_COPY_B)
                  || (dcmd.phase == sol_pkg::PH_COPY_T) || (dcmd.phase == sol_pkg::PH_COPY_C);
    assign is_rd   = (dcmd.phase == sol_pkg::PH_RD_BOT) || (dcmd.phase == sol_pkg::PH_RD_TOP)
                  || (dcmd.phase == sol_pkg::PH_RD_OUT);
    assign len     = (is_scan || is_copy) ? CW'(DECK_SIZE) : (is_rd ? CW'(1) : CW'(0));
    assign issue   = (cnt_reg != len);
    assign rdata   = bank_reg ? rd1 : rd0;
    assign j       = IW'(cnt_reg);

    // joker moves as a relocation
    always_comb
    begin
        rf     = IW'(pa_reg);
        rt     = IW'(pa_reg);
        rel_id = 1'b1;
        if (dcmd.phase == sol_pkg::PH_COPY_A)
        begin
            rf     = IW'(pa_reg);
            rt     = (rf == LAST_I) ? ONE_I : rf + ONE_I;
            rel_id = !fa_reg;
        end
        else
        begin
            rf     = IW'(pb_reg);
            rt     = (rf == LAST_I) ? TWO_I : ((rf == LAST_I - ONE_I) ? ONE_I : rf + TWO_I);
            rel_id = !fb_reg;
        end
    end

    assign n1       = LAST_I - IW'(hi_reg);
    assign mid      = IW'(hi_reg) - IW'(lo_reg) + ONE_I;
    assign vi       = IW'(v_reg);
    assign ncut     = LAST_I - vi;
    assign cut_skip = is_jk(v_reg) || (vi == '0) || (vi >= LAST_I);

    always_comb
    begin
        src = j;
        case (dcmd.phase)
            sol_pkg::PH_COPY_A, sol_pkg::PH_COPY_B:
            begin
                if (!rel_id && rf < rt)
                begin
                    if (j == rt)
                        src = rf;
                    else if (j >= rf && j < rt)
                        src = j + ONE_I;
                end
                else if (!rel_id && rf > rt)
                begin
                    if (j == rt)
                        src = rf;
                    else if (j > rt && j <= rf)
                        src = j - ONE_I;
                end
            end
            sol_pkg::PH_COPY_T:
            begin
                if (fj_reg)
                begin
                    if (j < n1)
                        src = IW'(hi_reg) + ONE_I + j;
                    else if (j < n1 + mid)
                        src = IW'(lo_reg) + j - n1;
                    else
                        src = j - n1 - mid;
                end
            end
            sol_pkg::PH_COPY_C:
            begin
                if (!cut_skip)
                begin
                    if (j < ncut)
                        src = vi + j;
                    else if (j < LAST_I)
                        src = j - ncut;
                end
            end
            default: src = j;
        endcase
    end

    assign ts = (is_jk(t_reg) || IW'(t_reg) >= N_I) ? LAST_I : IW'(t_reg);

    always_comb
    begin
        case (dcmd.phase)
            sol_pkg::PH_RD_BOT: raddr = AW'(DECK_SIZE - 1);
            sol_pkg::PH_RD_TOP: raddr = '0;
            sol_pkg::PH_RD_OUT: raddr = ts[AW-1:0];
            default:            raddr = is_copy ? src[AW-1:0] : cnt_reg[AW-1:0];
        endcase
    end

    logic                       cp_we, ld_we;
    logic                       we0, we1;
    logic [AW-1:0]              waddr;
    logic [sol_pkg::CARD_W-1:0] wdata;

    assign cp_we = pv_reg && is_copy;
    assign ld_we = dcmd.load && (IW'(item.position) < N_I);
    assign waddr = cp_we ? pidx_reg : item.position[AW-1:0];
    assign wdata = cp_we ? rdata : item.card;
    assign we0   = (cp_we && bank_reg) || (ld_we && !bank_reg);
    assign we1   = (cp_we && !bank_reg) || (ld_we && bank_reg);

    sol_ram #(.WIDTH(sol_pkg::CARD_W), .DEPTH(DECK_SIZE)) u_ram0 (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd0)
    );

    sol_ram #(.WIDTH(sol_pkg::CARD_W), .DEPTH(DECK_SIZE)) u_ram1 (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            pv_reg      <= 1'b0;
            bank_reg    <= 1'b0;
            fa_reg      <= 1'b0;
            fb_reg      <= 1'b0;
            fj_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (dcmd.clr)
            begin
                cnt_reg <= '0;
                pv_reg  <= 1'b0;
            end
            else
            begin
                pv_reg <= issue;
                if (issue)
                    cnt_reg <= cnt_reg + CW'(1);
            end
            if (dcmd.flip)
                bank_reg <= !bank_reg;
            if (dcmd.clr_scan)
            begin
                fa_reg <= 1'b0;
                fb_reg <= 1'b0;
                fj_reg <= 1'b0;
            end
            else if (pv_reg)
            begin
                if (dcmd.phase == sol_pkg::PH_SCAN_A && IW'(rdata) == LAST_I)
                    fa_reg <= 1'b1;
                if (dcmd.phase == sol_pkg::PH_SCAN_B && IW'(rdata) == N_I)
                    fb_reg <= 1'b1;
                if (dcmd.phase == sol_pkg::PH_SCAN_T && is_jk(rdata))
                    fj_reg <= 1'b1;
            end
            if (dcmd.emit)
                out_vld_reg <= 1'b1;
            else if (!result_stall)
                out_vld_reg <= 1'b0;
        end
    end

    logic [sol_pkg::LET_W-1:0] key, lr;
    logic [sol_pkg::LET_W:0]   s;

    assign key = dcmd.key_zero ? '0
               : (c_reg >= 6'd52 ? 5'(c_reg - 6'd52)
               : (c_reg >= 6'd26 ? 5'(c_reg - 6'd26) : 5'(c_reg)));
    assign lr  = (let_reg >= 5'd26) ? let_reg - 5'd26 : let_reg;
    assign s   = (op_reg == sol_pkg::OP_ENC) ? {1'b0, lr} + {1'b0, key}
                                             : {1'b0, lr} + 6'd26 - {1'b0, key};

    always_ff @(posedge clk)
    begin
        if (issue && !dcmd.clr)
            pidx_reg <= (is_copy ? cnt_reg[AW-1:0] : raddr);
        if (pv_reg && !dcmd.clr_scan)
        begin
            unique case (dcmd.phase)
                sol_pkg::PH_SCAN_A: if (IW'(rdata) == LAST_I && !fa_reg) pa_reg <= pidx_reg;
                sol_pkg::PH_SCAN_B: if (IW'(rdata) == N_I && !fb_reg) pb_reg <= pidx_reg;
                sol_pkg::PH_SCAN_T:
                begin
                    if (is_jk(rdata))
                    begin
                        if (!fj_reg)
                            lo_reg <= pidx_reg;
                        hi_reg <= pidx_reg;
                    end
                end
                sol_pkg::PH_RD_BOT: v_reg <= rdata;
                sol_pkg::PH_RD_TOP: t_reg <= rdata;
                sol_pkg::PH_RD_OUT: c_reg <= rdata;
                default: ;
            endcase
        end
        if (dcmd.start)
        begin
            op_reg  <= item.cmd;
            let_reg <= item.letter;
        end
        if (dcmd.emit)
        begin
            if (dcmd.zero)
                out_reg <= '0;
            else
            begin
                out_reg.out_letter <= (s >= 6'd26) ? 5'(s - 6'd26) : s[sol_pkg::LET_W-1:0];
                out_reg.key_value  <= key;
            end
        end
    end

    assign dsts.done     = (cnt_reg == len) && !pv_reg;
    assign dsts.c_joker  = is_jk(c_reg);
    assign dsts.out_free = !out_vld_reg || !result_stall;
    assign result_valid  = out_vld_reg;
    assign result        = out_reg;

endmodule

// ===== src/sol_ctrl.sv =====
module sol_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  logic [sol_pkg::CMD_W-1:0]  item_cmd,
    output logic                       item_stall,
    input  sol_pkg::dp_sts_t           dsts,
    output sol_pkg::dp_cmd_t           dcmd
);

    logic [3:0]                state_reg, state_next;
    logic [sol_pkg::RND_W-1:0] round_reg, round_next;
    logic                      kz_reg, kz_next;
    logic                      accept, is_key;

    assign item_stall = !((state_reg == sol_pkg::PH_IDLE) && dsts.out_free);
    assign accept     = item_valid && !item_stall;
    assign is_key     = (item_cmd == sol_pkg::OP_ENC) || (item_cmd == sol_pkg::OP_DEC);

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        kz_next    = kz_reg;
        unique case (state_reg)
            sol_pkg::PH_IDLE:
            begin
                if (accept && is_key)
                begin
                    state_next = sol_pkg::PH_SCAN_A;
                    round_next = '0;
                end
            end
            sol_pkg::PH_SCAN_A: if (dsts.done) state_next = sol_pkg::PH_COPY_A;
            sol_pkg::PH_COPY_A: if (dsts.done) state_next = sol_pkg::PH_SCAN_B;
            sol_pkg::PH_SCAN_B: if (dsts.done) state_next = sol_pkg::PH_COPY_B;
            sol_pkg::PH_COPY_B: if (dsts.done) state_next = sol_pkg::PH_SCAN_T;
            sol_pkg::PH_SCAN_T: if (dsts.done) state_next = sol_pkg::PH_COPY_T;
            sol_pkg::PH_COPY_T: if (dsts.done) state_next = sol_pkg::PH_RD_BOT;
            sol_pkg::PH_RD_BOT: if (dsts.done) state_next = sol_pkg::PH_COPY_C;
            sol_pkg::PH_COPY_C: if (dsts.done) state_next = sol_pkg::PH_RD_TOP;
            sol_pkg::PH_RD_TOP: if (dsts.done) state_next = sol_pkg::PH_RD_OUT;
            sol_pkg::PH_RD_OUT:
            begin
                if (dsts.done)
                begin
                    if (!dsts.c_joker)
                    begin
                        state_next = sol_pkg::PH_EMIT;
                        kz_next    = 1'b0;
                    end
                    else if (round_reg == sol_pkg::RND_W'(sol_pkg::MAX_ROUNDS - 1))
                    begin
                        state_next = sol_pkg::PH_EMIT;
                        kz_next    = 1'b1;
                    end
                    else
                    begin
                        state_next = sol_pkg::PH_SCAN_A;
                        round_next = round_reg + 1'b1;
                    end
                end
            end
            sol_pkg::PH_EMIT: if (dsts.out_free) state_next = sol_pkg::PH_IDLE;
            default: state_next = sol_pkg::PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sol_pkg::PH_IDLE;
            round_reg <= '0;
            kz_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            kz_reg    <= kz_next;
        end
    end

    always_comb
    begin
        dcmd.phase    = state_reg;
        dcmd.clr      = (state_next != state_reg);
        dcmd.clr_scan = dcmd.clr && ((state_next == sol_pkg::PH_SCAN_A)
                     || (state_next == sol_pkg::PH_SCAN_B) || (state_next == sol_pkg::PH_SCAN_T));
        dcmd.flip     = dsts.done && ((state_reg == sol_pkg::PH_COPY_A)
                     || (state_reg == sol_pkg::PH_COPY_B) || (state_reg == sol_pkg::PH_COPY_T)
                     || (state_reg == sol_pkg::PH_COPY_C));
        dcmd.start    = accept && is_key;
        dcmd.load     = accept && (item_cmd == sol_pkg::OP_LOAD);
        dcmd.emit     = (accept && !is_key)
                     || ((state_reg == sol_pkg::PH_EMIT) && dsts.out_free);
        dcmd.zero     = (state_reg == sol_pkg::PH_IDLE);
        dcmd.key_zero = kz_reg;
    end

endmodule

// ===== src/solitaire_keystream_cipher.sv =====
// Solitaire keystream cipher over a deck of DECK_SIZE cards held in two RAM copies that
// are used in turn. A load beat writes one card and returns a zero result.
// An encrypt or decrypt beat runs keystream rounds; each round is three scans and four
// copy passes over the deck plus three single reads, all through the one read port
// of the deck RAM; the round repeats for every joker output card, up to 256 rounds,
// and the emit state then returns the result once the output is free.
// One beat is worked on at a time.
`include "assert_macros.svh"

module solitaire_keystream_cipher #(
    parameter int DECK_SIZE = 54
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  sol_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output sol_pkg::result_t result
);

    sol_pkg::dp_cmd_t dcmd;
    sol_pkg::dp_sts_t dsts;
    logic             key_acc;

    assign key_acc = item_valid && !item_stall
                  && (item.cmd == sol_pkg::OP_ENC || item.cmd == sol_pkg::OP_DEC);

    sol_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_cmd   (item.cmd),
        .item_stall (item_stall),
        .dsts       (dsts),
        .dcmd       (dcmd)
    );

    sol_dp #(.DECK_SIZE(DECK_SIZE)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .dcmd         (dcmd),
        .dsts         (dsts),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `ASSERT_NEXT(a_busy, clk, rst_n, key_acc, item_stall)
    `ASSERT_IMP(a_flip, clk, rst_n, dcmd.flip, dsts.done)
    `ASSERT_IMP(a_emit, clk, rst_n, dcmd.emit, dsts.out_free)

endmodule
